FILE: rtl/tcs_pkg.sv
// ----------------------------------------------------------------------------
// tcs_pkg: text console scrollback definitions
// Geometry of the scrollback ring, request codes, state codes and the
// character constants shared by the console logic.
// ----------------------------------------------------------------------------
package tcs_pkg;

    // ring geometry
    localparam int RING_LINES    = 256;
    localparam int LINE_WIDTH    = 48;
    localparam int VISIBLE_LINES = 20;

    // memory layout: one row per ring line, 64 cell slots per row
    localparam int ROW_W     = $clog2(RING_LINES);
    localparam int COL_W     = 6;
    localparam int ADDR_W    = ROW_W + COL_W;
    localparam int MEM_DEPTH = RING_LINES * (2 ** COL_W);

    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(LINE_WIDTH);
    localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(RING_LINES - 1);
    localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(MEM_DEPTH - 1);
    localparam logic [31:0]       RING_SPAN = 32'(RING_LINES);
    localparam logic [31:0]       VIS_SPAN  = 32'(VISIBLE_LINES);

    // character handling
    localparam logic [7:0]  CHAR_NUL    = 8'h00;
    localparam logic [7:0]  CHAR_NL     = 8'h0A;
    localparam logic [7:0]  CHAR_BTICK  = 8'h60;
    localparam logic [15:0] OFFS_LOWER  = 16'h0040;
    localparam logic [15:0] OFFS_UPPER  = 16'h0020;

    // request codes
    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_SCROLL = 2'd1,
        REQ_READ   = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req;

    // sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_CHAR,
        ST_RDATA,
        ST_CLEAR
    } t_state;

endpackage

FILE: rtl/tcs_ram.sv
// ----------------------------------------------------------------------------
// tcs_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/text_console_scrollback_unit.sv
// Sequence: an accepted request enters the execute state, where a scroll or a plain
// character finishes; a read (registered RAM read) then passes the read-data state, a
// character that wraps the line (two RAM writes) the character state, and a clear walks
// column 0 of every row in the clear state. The next request is taken in the cycle the
// previous result shows; the receiver cannot stall.
// Reset: a clearing pass zeroes the text RAM with busy high throughout.
// ----------------------------------------------------------------------------
// text_console_scrollback_unit: text console with scrollback ring
// Stores characters into a ring of text rows held in one RAM, follows the
// write cursor with the view, handles scroll events, cell reads and clears.
// ----------------------------------------------------------------------------
module text_console_scrollback_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_tile_base_we,
    input  logic [15:0] i_tile_base,
    // request
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_req_type,
    input  logic [7:0]  i_char_code,
    input  logic        i_up_held,
    input  logic        i_down_held,
    input  logic        i_back_pressed,
    input  logic [4:0]  i_view_row,
    input  logic [5:0]  i_column,
    // result
    output logic        o_valid,
    output logic [7:0]  o_cell_char,
    output logic        o_cell_is_end,
    output logic [15:0] o_tile_index,
    output logic        o_keep_open,
    output logic [31:0] o_view_top,
    output logic [31:0] o_cursor_line,
    output logic [5:0]  o_cursor_column
);

    tcs_pkg::t_state r_state, n_state;

    logic [tcs_pkg::ADDR_W-1:0] r_cnt, n_cnt;
    logic [tcs_pkg::COL_W-1:0]  r_wcol, n_wcol;
    logic [31:0]                r_wline, n_wline;
    logic [31:0]                r_dtop, n_dtop;
    logic [15:0]                r_tile_base;
    logic                       r_valid, n_valid;

    // captured request beat
    tcs_pkg::t_req             r_req;
    logic [7:0]                r_char;
    logic                      r_up, r_down, r_back;
    logic [4:0]                r_view_row;
    logic [tcs_pkg::COL_W-1:0] r_column;
    logic                      r_col_ok;

    // result payload
    logic [7:0]  r_cell_char, n_cell_char;
    logic        r_cell_is_end, n_cell_is_end;
    logic [15:0] r_tile_index, n_tile_index;
    logic        r_keep_open, n_keep_open;

    // text RAM port signals
    logic                       ram_we, ram_re;
    logic [tcs_pkg::ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]                 ram_wdata, ram_rdata;

    // helpers
    logic                      accept;
    logic                      do_char;
    logic [7:0]                store_ch;
    logic [31:0]               wline_new;
    logic [31:0]               scr_top, scr_bottom, dtop_up;
    logic [tcs_pkg::ROW_W-1:0] read_row;
    logic [7:0]                rd_ch;

    assign accept   = i_start && !o_busy;
    assign store_ch = (r_char == tcs_pkg::CHAR_NL) ? tcs_pkg::CHAR_NUL : r_char;
    assign read_row = r_dtop[tcs_pkg::ROW_W-1:0] + tcs_pkg::ROW_W'(r_view_row);
    assign rd_ch    = r_col_ok ? ram_rdata : tcs_pkg::CHAR_NUL;

    // scroll bounds
    assign scr_top    = (r_wline > tcs_pkg::RING_SPAN) ? r_wline - tcs_pkg::RING_SPAN : 32'd0;
    assign scr_bottom = (r_wline > tcs_pkg::VIS_SPAN) ? r_wline - tcs_pkg::VIS_SPAN : 32'd0;
    assign dtop_up    = (r_up && (scr_top < r_dtop)) ? r_dtop - 32'd1 : r_dtop;

    // text store
    tcs_ram #(
        .WIDTH (8),
        .DEPTH (tcs_pkg::MEM_DEPTH)
    ) u_text_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcs_pkg::ST_INIT;
            r_cnt       <= '0;
            r_wcol      <= '0;
            r_wline     <= '0;
            r_dtop      <= '0;
            r_valid     <= 1'b0;
            r_tile_base <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_wcol  <= n_wcol;
            r_wline <= n_wline;
            r_dtop  <= n_dtop;
            r_valid <= n_valid;
            if (i_tile_base_we) begin
                r_tile_base <= i_tile_base;
            end
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req      <= tcs_pkg::t_req'(i_req_type);
            r_char     <= i_char_code;
            r_up       <= i_up_held;
            r_down     <= i_down_held;
            r_back     <= i_back_pressed;
            r_view_row <= i_view_row;
            r_column   <= i_column;
            r_col_ok   <= (i_column <= tcs_pkg::COL_LAST);
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_cell_char   <= n_cell_char;
        r_cell_is_end <= n_cell_is_end;
        r_tile_index  <= n_tile_index;
        r_keep_open   <= n_keep_open;
    end

    // sequencer: next state, RAM accesses, cursor and view updates
    always_comb begin
        n_state       = r_state;
        n_cnt         = r_cnt;
        n_wcol        = r_wcol;
        n_wline       = r_wline;
        n_dtop        = r_dtop;
        n_valid       = 1'b0;
        n_cell_char   = 8'd0;
        n_cell_is_end = 1'b0;
        n_tile_index  = 16'd0;
        n_keep_open   = 1'b1;
        ram_we        = 1'b0;
        ram_waddr     = '0;
        ram_wdata     = tcs_pkg::CHAR_NUL;
        ram_re        = 1'b0;
        ram_raddr     = {read_row, r_column};
        do_char       = 1'b0;
        wline_new     = r_wline;

        unique case (r_state)
            tcs_pkg::ST_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == tcs_pkg::ADDR_LAST) begin
                    n_state = tcs_pkg::ST_IDLE;
                end
            end
            tcs_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = tcs_pkg::ST_EXEC;
                end
            end
            tcs_pkg::ST_EXEC: begin
                unique case (r_req)
                    tcs_pkg::REQ_WRITE: begin
                        if (r_wcol >= tcs_pkg::COL_LAST) begin
                            // line full: close it with a terminator first
                            ram_we    = 1'b1;
                            ram_waddr = {r_wline[tcs_pkg::ROW_W-1:0], tcs_pkg::COL_LAST};
                            n_wline   = r_wline + 32'd1;
                            n_wcol    = '0;
                            n_state   = tcs_pkg::ST_CHAR;
                        end else begin
                            do_char = 1'b1;
                        end
                    end
                    tcs_pkg::REQ_SCROLL: begin
                        if (!r_back) begin
                            n_dtop = (r_down && (scr_bottom > dtop_up)) ? dtop_up + 32'd1
                                                                         : dtop_up;
                        end
                        n_keep_open = !r_back;
                        n_valid     = 1'b1;
                        n_state     = tcs_pkg::ST_IDLE;
                    end
                    tcs_pkg::REQ_READ: begin
                        ram_re  = 1'b1;
                        n_state = tcs_pkg::ST_RDATA;
                    end
                    tcs_pkg::REQ_CLEAR: begin
                        n_cnt   = '0;
                        n_state = tcs_pkg::ST_CLEAR;
                    end
                    default: begin
                        n_state = tcs_pkg::ST_IDLE;
                    end
                endcase
            end
            tcs_pkg::ST_CHAR: begin
                do_char = 1'b1;
            end
            tcs_pkg::ST_RDATA: begin
                n_cell_char   = rd_ch;
                n_cell_is_end = (rd_ch == tcs_pkg::CHAR_NUL);
                n_tile_index  = r_tile_base + 16'(rd_ch)
                              - ((rd_ch > tcs_pkg::CHAR_BTICK) ? tcs_pkg::OFFS_LOWER
                                                               : tcs_pkg::OFFS_UPPER);
                n_valid       = 1'b1;
                n_state       = tcs_pkg::ST_IDLE;
            end
            tcs_pkg::ST_CLEAR: begin
                // empty one ring row per cycle
                ram_we    = 1'b1;
                ram_waddr = {r_cnt[tcs_pkg::ROW_W-1:0], {tcs_pkg::COL_W{1'b0}}};
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt[tcs_pkg::ROW_W-1:0] == tcs_pkg::ROW_LAST) begin
                    n_wline = '0;
                    n_wcol  = '0;
                    n_valid = 1'b1;
                    n_state = tcs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tcs_pkg::ST_IDLE;
            end
        endcase

        // character store, cursor advance and auto-scroll
        if (do_char) begin
            ram_we    = 1'b1;
            ram_waddr = {r_wline[tcs_pkg::ROW_W-1:0], r_wcol};
            ram_wdata = store_ch;
            if (store_ch == tcs_pkg::CHAR_NUL) begin
                wline_new = r_wline + 32'd1;
                n_wcol    = '0;
            end else begin
                n_wcol    = r_wcol + 1'b1;
            end
            n_wline = wline_new;
            if (wline_new > r_dtop + tcs_pkg::VIS_SPAN) begin
                n_dtop = wline_new - tcs_pkg::VIS_SPAN;
            end
            n_valid = 1'b1;
            n_state = tcs_pkg::ST_IDLE;
        end
    end

    // ports
    assign o_busy          = (r_state != tcs_pkg::ST_IDLE);
    assign o_valid         = r_valid;
    assign o_cell_char     = r_cell_char;
    assign o_cell_is_end   = r_cell_is_end;
    assign o_tile_index    = r_tile_index;
    assign o_keep_open     = r_keep_open;
    assign o_view_top      = r_dtop;
    assign o_cursor_line   = r_wline;
    assign o_cursor_column = r_wcol;

`ifndef ASSERT_OFF
    // a result beat only follows a cycle of work
    a_valid_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy))
        else $error("result beat without preceding work");

    // an accepted beat always occupies the sequencer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("accepted beat did not start work");

    // the cursor never runs past the terminator column
    a_cursor_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cursor_column <= tcs_pkg::COL_LAST))
        else $error("cursor column beyond line width");

    // the text RAM is never written while idle
    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcs_pkg::ST_IDLE) |-> !ram_we)
        else $error("text RAM written while idle");
`endif

endmodule
